// ===== rtl/zssd_pkg.sv =====
// Package for the zero-suppressed sequence decoder: item, state and result
// types, result kind codes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package zssd_pkg;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_NEW       = 3'd1,
    KIND_MERGED    = 3'd2,
    KIND_END       = 3'd3,
    KIND_IGNORED   = 3'd4,
    KIND_NO_HEADER = 3'd5,
    KIND_BACKWARDS = 3'd6
  } zssd_kind_t;

  // Pad number that marks the end of a bank
  localparam logic [7:0]  PAD_END        = 8'hFF;
  // Saturation limits of the sequence counter and the merged length
  localparam logic [8:0]  SEQ_COUNT_MAX  = 9'h1FF;
  localparam logic [10:0] MERGED_LEN_MAX = 11'h7FF;
  // Last bin value before any sequence of a pad (minus two)
  localparam logic [11:0] LAST_BIN_CLEAR = 12'hFFE;

  // One input item
  typedef struct packed {
    logic        bank_start;
    logic [15:0] data_word;
  } zssd_item_t;

  // Bank decoding state, apart from the running byte offset
  typedef struct packed {
    logic [6:0]  row;
    logic [7:0]  pad;
    logic        header_seen;
    logic        halted;
    logic [11:0] last_bin;
    logic [9:0]  prev_start;
    logic [8:0]  seq_count;
    logic [9:0]  seq_start;
    logic [10:0] merged_len;
  } zssd_state_t;

  localparam zssd_state_t STATE_CLEAR = '{
    row:         7'd0,
    pad:         8'd0,
    header_seen: 1'b0,
    halted:      1'b0,
    last_bin:    LAST_BIN_CLEAR,
    prev_start:  10'd0,
    seq_count:   9'd0,
    seq_start:   10'd0,
    merged_len:  11'd0
  };

  // One result item
  typedef struct packed {
    zssd_kind_t  kind;
    logic [6:0]  pad_row;
    logic [7:0]  pad_number;
    logic [9:0]  start_bin;
    logic [10:0] seq_length;
    logic [15:0] adc_offset;
    logic [8:0]  seq_index;
    logic        pad_done;
  } zssd_result_t;

endpackage

// ===== rtl/zssd_if.sv =====
// Valid/ready channel interfaces for the zero-suppressed sequence decoder:
// the bank word input channel and the decoded result channel. No dependencies.
`timescale 1ns / 1ps

// Bank word channel
interface zssd_in_if;
  logic        valid;
  logic        ready;
  logic        bank_start;
  logic [15:0] data_word;

  modport source (output valid, output bank_start, output data_word, input ready);
  modport sink   (input valid, input bank_start, input data_word, output ready);
endinterface

// Decoded result channel
interface zssd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [6:0]  pad_row;
  logic [7:0]  pad_number;
  logic [9:0]  start_bin;
  logic [10:0] seq_length;
  logic [15:0] adc_offset;
  logic [8:0]  seq_index;
  logic        pad_done;

  modport source (output valid, output kind, output pad_row, output pad_number,
                  output start_bin, output seq_length, output adc_offset,
                  output seq_index, output pad_done, input ready);
  modport sink   (input valid, input kind, input pad_row, input pad_number,
                  input start_bin, input seq_length, input adc_offset,
                  input seq_index, input pad_done, output ready);
endinterface

// ===== rtl/zero_suppressed_sequence_decoder.sv =====
// Zero-suppressed sequence bank decoder, top level. Uses zssd_pkg, the
// channel interfaces and zssd_decode.
// An input word passes an input register and then a result register; a full result
// register that is not being read holds the word in the input register.
// Throughput: one word per cycle while the result channel is ready; the bank state loop
// closes through one decode stage between the input register and the result register.
// Reset: synchronous, active low; clears both stage valid flags, the bank state and offset.
`timescale 1ns / 1ps

module zero_suppressed_sequence_decoder #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  zssd_in_if.sink         in_ch,
  zssd_out_if.source      out_ch
);
  import zssd_pkg::*;

  zssd_item_t              item_r;
  logic                    item_valid_r;
  zssd_state_t             st_r;
  zssd_state_t             st_nxt;
  logic [OFFSET_WIDTH-1:0] off_r;
  logic [OFFSET_WIDTH-1:0] off_nxt;
  zssd_result_t            res_nxt;
  zssd_result_t            res_r;
  logic                    out_valid_r;
  logic                    advance;
  logic                    in_xfer;

  // Handshake: the input register moves on whenever the result register is free
  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.bank_start <= in_ch.bank_start;
      item_r.data_word  <= in_ch.data_word;
    end
  end

  // Word decode
  zssd_decode #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_decode (
    .item     (item_r),
    .st_cur   (st_r),
    .off_cur  (off_r),
    .st_next  (st_nxt),
    .off_next (off_nxt),
    .res      (res_nxt)
  );

  // Bank state, updated as each word is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_CLEAR;
      off_r <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      off_r <= off_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Result channel outputs
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.pad_row    = res_r.pad_row;
  assign out_ch.pad_number = res_r.pad_number;
  assign out_ch.start_bin  = res_r.start_bin;
  assign out_ch.seq_length = res_r.seq_length;
  assign out_ch.adc_offset = res_r.adc_offset;
  assign out_ch.seq_index  = res_r.seq_index;
  assign out_ch.pad_done   = res_r.pad_done;

`ifndef SYNTH
  // A halted bank reports every word as ignored until the next bank start
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && st_r.halted && !item_r.bank_start |=> res_r.kind == KIND_IGNORED)
    else $error("word in a halted bank not reported as ignored");

  // An end marker halts the bank
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.kind == KIND_END |=> st_r.halted)
    else $error("end marker did not halt the bank");

  // The byte offset never falls within a bank
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && advance && !item_r.bank_start |=> off_r >= $past(off_r))
    else $error("byte offset went backwards within a bank");

  // Only sequence words close a pad
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pad_done |-> res_r.kind == KIND_NEW || res_r.kind == KIND_MERGED)
    else $error("pad closed by a word that is not a sequence");
`endif

endmodule

// ===== rtl/zssd_decode.sv =====
// Combinational word decoder: from one bank word and the current bank state it
// forms the next state, the next byte offset and the result. Uses zssd_pkg.
`timescale 1ns / 1ps

module zssd_decode #(
  parameter int OFFSET_WIDTH = 16
) (
  input  zssd_pkg::zssd_item_t   item,
  input  zssd_pkg::zssd_state_t  st_cur,
  input  logic [OFFSET_WIDTH-1:0] off_cur,
  output zssd_pkg::zssd_state_t  st_next,
  output logic [OFFSET_WIDTH-1:0] off_next,
  output zssd_pkg::zssd_result_t res
);
  import zssd_pkg::*;

  zssd_state_t              st;
  logic [OFFSET_WIDTH-1:0]  off;
  logic [15:0]              w;
  logic [9:0]               start;
  logic [4:0]               len;
  logic signed [12:0]       last_plus_one;
  logic                     new_seq;
  logic [11:0]              merged_sum;
  logic [OFFSET_WIDTH:0]    off_sum;

  // A bank start clears the state before the word is decoded
  assign st  = item.bank_start ? STATE_CLEAR : st_cur;
  assign off = item.bank_start ? '0 : off_cur;

  // Field extraction
  assign w     = item.data_word;
  assign start = w[15:6];
  assign len   = w[4:0];

  // A sequence opens a new one when it starts beyond the last bin plus one
  assign last_plus_one = $signed({st.last_bin[11], st.last_bin}) + 13'sd1;
  assign new_seq       = $signed({3'b000, start}) > last_plus_one;

  // Length and offset sums, one bit wider to detect saturation
  assign merged_sum = {1'b0, st.merged_len} + {7'd0, len};
  assign off_sum    = {1'b0, off} + (OFFSET_WIDTH + 1)'(len);

  // Word decode
  always_comb begin
    st_next        = st;
    off_next       = off;
    res            = '0;
    res.kind       = KIND_IGNORED;
    res.pad_row    = st.row;
    res.pad_number = st.pad;
    res.adc_offset = 16'(off);

    if (st.halted) begin
      res.kind = KIND_IGNORED;
    end else if (w[15]) begin
      // Padrow and pad header, or the end of the bank
      st_next.row    = w[14:8];
      st_next.pad    = w[7:0];
      res.pad_row    = w[14:8];
      res.pad_number = w[7:0];
      if (w[7:0] == PAD_END) begin
        st_next.halted = 1'b1;
        res.kind       = KIND_END;
      end else begin
        st_next.header_seen = 1'b1;
        st_next.seq_count   = '0;
        st_next.prev_start  = '0;
        res.kind            = KIND_HEADER;
      end
    end else if (!st.header_seen) begin
      st_next.halted = 1'b1;
      res.kind       = KIND_NO_HEADER;
      res.start_bin  = start;
      res.seq_length = {6'd0, len};
    end else if (start < st.prev_start) begin
      st_next.halted = 1'b1;
      res.kind       = KIND_BACKWARDS;
      res.start_bin  = start;
      res.seq_length = {6'd0, len};
    end else begin
      // Sequence word: open a new sequence or extend the current one
      if (new_seq) begin
        res.kind           = KIND_NEW;
        st_next.seq_start  = start;
        st_next.merged_len = {6'd0, len};
        res.seq_index      = st.seq_count;
        if (st.seq_count != SEQ_COUNT_MAX) begin
          st_next.seq_count = st.seq_count + 9'd1;
        end
      end else begin
        res.kind           = KIND_MERGED;
        st_next.merged_len = merged_sum[11] ? MERGED_LEN_MAX : merged_sum[10:0];
        res.seq_index      = (st.seq_count != '0) ? st.seq_count - 9'd1 : '0;
      end
      st_next.last_bin   = {2'b00, start} + {7'd0, len} - 12'd1;
      st_next.prev_start = start;

      // Last sequence of the pad moves on to the next pad
      if (w[5]) begin
        res.pad_done       = 1'b1;
        st_next.pad        = st.pad + 8'd1;
        st_next.seq_count  = '0;
        st_next.last_bin   = LAST_BIN_CLEAR;
        st_next.prev_start = '0;
      end

      res.start_bin  = st_next.seq_start;
      res.seq_length = st_next.merged_len;
      off_next       = off_sum[OFFSET_WIDTH] ? '1 : off_sum[OFFSET_WIDTH-1:0];
    end
  end

endmodule
